FILE: rtl/cbe_pkg.sv
package cbe_pkg;

  localparam int CTRL_W = 17;
  localparam int IN_W   = 17;
  localparam int OUT_W  = 17;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_SEARCH_STEPS  = 10;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic [CTRL_W-1:0] RST_X_CONTROL_ONE = CTRL_W'(29491);
  localparam logic [CTRL_W-1:0] RST_X_CONTROL_TWO = CTRL_W'(36045);
  localparam logic [CTRL_W-1:0] RST_Y_CONTROL_ONE = CTRL_W'(29491);
  localparam logic [CTRL_W-1:0] RST_Y_CONTROL_TWO = CTRL_W'(60293);

  localparam logic [CFG_IDX_W-1:0] REG_X_CONTROL_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_CONTROL_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CONTROL_ONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CONTROL_TWO = 2'd3;

  // register stages in one cubic evaluation
  localparam int CUBIC_STAGES = 3;

  // width of 3*t1 + 3*t2 + t3: terms scaled by a control point stay below 2^CTRL_W
  function automatic int sum_width(input int fb);
    int w;
    begin
      w = (fb + 1 > CTRL_W + 2) ? fb + 1 : CTRL_W + 2;
      return w + 2;
    end
  endfunction

endpackage

FILE: rtl/cubic_bezier_ease_top.sv
// Cubic Bezier easing: maps a linear progress fraction (unsigned, FRACTION_BITS fraction bits)
// to an eased fraction. Zero gives zero, one or more gives one; otherwise SEARCH_STEPS
// bisection cells find the curve parameter, and a last cubic evaluates y there, saturated
// to one. One request is taken per cycle while the output is not stalled. Each cell runs
// an x cubic and registers the new bounds; the y cubic feeds an output register. The pipeline
// advances as a whole, so a stalled result holds every stage. Write control points only
// while no request is in flight.
module cubic_bezier_ease_top
  import cbe_pkg::*;
#(
  parameter int SEARCH_STEPS  = DEF_SEARCH_STEPS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CTRL_W-1:0]    cfg_data,
  input  logic                 progress_valid,
  output logic                 progress_stall,
  input  logic [IN_W-1:0]      progress,
  output logic                 eased_valid,
  input  logic                 eased_stall,
  output logic [OUT_W-1:0]     eased
);

  localparam int FB = FRACTION_BITS;
  localparam int VW = FB + 1;
  localparam int SW = sum_width(FB);
  localparam int D  = CUBIC_STAGES;
  localparam int N  = SEARCH_STEPS;
  localparam logic [63:0]    ONE64   = 64'(1) << FB;
  localparam logic [VW-1:0]  ONE     = ONE64[VW-1:0];
  localparam logic [OUT_W-1:0] ONE_OUT = ONE64[OUT_W-1:0];

  logic [CTRL_W-1:0] x_control_one, x_control_two, y_control_one, y_control_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_control_one <= RST_X_CONTROL_ONE;
      x_control_two <= RST_X_CONTROL_TWO;
      y_control_one <= RST_Y_CONTROL_ONE;
      y_control_two <= RST_Y_CONTROL_TWO;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_CONTROL_ONE: x_control_one <= cfg_data;
        REG_X_CONTROL_TWO: x_control_two <= cfg_data;
        REG_Y_CONTROL_ONE: y_control_one <= cfg_data;
        REG_Y_CONTROL_TWO: y_control_two <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en             = !eased_valid || !eased_stall;
  assign progress_stall = !en;

  logic [63:0]      t_ext;
  logic             t_zero, t_full;
  assign t_ext  = 64'(progress);
  assign t_zero = progress == '0;
  assign t_full = t_ext >= ONE64;

  logic              l_valid   [N+1];
  logic [IN_W-1:0]   l_t       [N+1];
  logic [VW-1:0]     l_lo      [N+1];
  logic [VW-1:0]     l_hi      [N+1];
  logic [VW-1:0]     l_u       [N+1];
  logic              l_byp     [N+1];
  logic [OUT_W-1:0]  l_byp_val [N+1];

  assign l_valid[0]   = progress_valid;
  assign l_t[0]       = progress;
  assign l_lo[0]      = '0;
  assign l_hi[0]      = ONE;
  assign l_u[0]       = t_ext[VW-1:0];
  assign l_byp[0]     = t_zero || t_full;
  assign l_byp_val[0] = t_zero ? '0 : ONE_OUT;

  for (genvar g = 0; g < N; g++) begin : g_cell
    cbe_cell #(.FRACTION_BITS(FB)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .c1          (x_control_one),
      .c2          (x_control_two),
      .in_valid    (l_valid[g]),
      .in_t        (l_t[g]),
      .in_lo       (l_lo[g]),
      .in_hi       (l_hi[g]),
      .in_u        (l_u[g]),
      .in_byp      (l_byp[g]),
      .in_byp_val  (l_byp_val[g]),
      .out_valid   (l_valid[g+1]),
      .out_t       (l_t[g+1]),
      .out_lo      (l_lo[g+1]),
      .out_hi      (l_hi[g+1]),
      .out_u       (l_u[g+1]),
      .out_byp     (l_byp[g+1]),
      .out_byp_val (l_byp_val[g+1])
    );
  end

  logic [SW-1:0] y;

  cbe_cubic #(.FRACTION_BITS(FB)) u_y_cubic (
    .clk (clk),
    .en  (en),
    .u   (l_u[N]),
    .c1  (y_control_one),
    .c2  (y_control_two),
    .sum (y)
  );

  logic             valid_d   [D];
  logic             byp_d     [D];
  logic [OUT_W-1:0] byp_val_d [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) valid_d[i] <= 1'b0;
      eased_valid <= 1'b0;
    end else if (en) begin
      valid_d[0] <= l_valid[N];
      for (int i = 1; i < D; i++) valid_d[i] <= valid_d[i-1];
      eased_valid <= valid_d[D-1];
    end
  end

  logic [OUT_W-1:0] eased_next;
  always_comb begin
    if (byp_d[D-1]) begin
      eased_next = byp_val_d[D-1];
    end else if (64'(y) > ONE64) begin
      eased_next = ONE_OUT;
    end else begin
      eased_next = y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_d[0]     <= l_byp[N];
      byp_val_d[0] <= l_byp_val[N];
      for (int i = 1; i < D; i++) begin
        byp_d[i]     <= byp_d[i-1];
        byp_val_d[i] <= byp_val_d[i-1];
      end
      eased <= eased_next;
    end
  end

endmodule

FILE: rtl/cbe_cubic.sv
module cbe_cubic
  import cbe_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [FRACTION_BITS:0]            u,
  input  logic [CTRL_W-1:0]                 c1,
  input  logic [CTRL_W-1:0]                 c2,
  output logic [sum_width(FRACTION_BITS)-1:0] sum
);

  localparam int FB = FRACTION_BITS;
  localparam int VW = FB + 1;
  localparam int SW = sum_width(FB);
  localparam logic [VW-1:0] ONE = VW'(1) << FB;

  logic [VW-1:0]        inv;
  logic [2*VW-1:0]      m_ii, m_iu, m_uu;
  logic [2*VW-1:0]      m_q1, m_q2, m_q3;
  logic [VW+CTRL_W-1:0] m_r1, m_r2;

  logic [VW-1:0]     p_ii, p_iu, p_uu, u_s1;
  logic [VW-1:0]     q1, q2, q3;
  logic [CTRL_W-1:0] r1, r2;
  logic [VW-1:0]     r3;

  assign inv  = ONE - u;
  assign m_ii = inv * inv;
  assign m_iu = inv * u;
  assign m_uu = u * u;
  assign m_q1 = p_ii * u_s1;
  assign m_q2 = p_iu * u_s1;
  assign m_q3 = p_uu * u_s1;
  assign m_r1 = q1 * c1;
  assign m_r2 = q2 * c2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ii <= m_ii[FB +: VW];
      p_iu <= m_iu[FB +: VW];
      p_uu <= m_uu[FB +: VW];
      u_s1 <= u;
      q1   <= m_q1[FB +: VW];
      q2   <= m_q2[FB +: VW];
      q3   <= m_q3[FB +: VW];
      r1   <= m_r1[FB +: CTRL_W];
      r2   <= m_r2[FB +: CTRL_W];
      r3   <= q3;
    end
  end

  assign sum = SW'(r1) + SW'({r1, 1'b0}) + SW'(r2) + SW'({r2, 1'b0}) + SW'(r3);

endmodule

FILE: rtl/cbe_cell.sv
module cbe_cell
  import cbe_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [CTRL_W-1:0]        c1,
  input  logic [CTRL_W-1:0]        c2,
  input  logic                     in_valid,
  input  logic [IN_W-1:0]          in_t,
  input  logic [FRACTION_BITS:0]   in_lo,
  input  logic [FRACTION_BITS:0]   in_hi,
  input  logic [FRACTION_BITS:0]   in_u,
  input  logic                     in_byp,
  input  logic [OUT_W-1:0]         in_byp_val,
  output logic                     out_valid,
  output logic [IN_W-1:0]          out_t,
  output logic [FRACTION_BITS:0]   out_lo,
  output logic [FRACTION_BITS:0]   out_hi,
  output logic [FRACTION_BITS:0]   out_u,
  output logic                     out_byp,
  output logic [OUT_W-1:0]         out_byp_val
);

  localparam int VW = FRACTION_BITS + 1;
  localparam int SW = sum_width(FRACTION_BITS);
  localparam int D  = CUBIC_STAGES;

  logic [SW-1:0] x;

  logic              valid_d   [D];
  logic [IN_W-1:0]   t_d       [D];
  logic [VW-1:0]     lo_d      [D];
  logic [VW-1:0]     hi_d      [D];
  logic [VW-1:0]     u_d       [D];
  logic              byp_d     [D];
  logic [OUT_W-1:0]  byp_val_d [D];

  logic          below;
  logic [VW-1:0] lo_next, hi_next;
  logic [VW:0]   mid;

  cbe_cubic #(.FRACTION_BITS(FRACTION_BITS)) u_cubic (
    .clk (clk),
    .en  (en),
    .u   (in_u),
    .c1  (c1),
    .c2  (c2),
    .sum (x)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) valid_d[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_d[0] <= in_valid;
      for (int i = 1; i < D; i++) valid_d[i] <= valid_d[i-1];
      out_valid <= valid_d[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0]       <= in_t;
      lo_d[0]      <= in_lo;
      hi_d[0]      <= in_hi;
      u_d[0]       <= in_u;
      byp_d[0]     <= in_byp;
      byp_val_d[0] <= in_byp_val;
      for (int i = 1; i < D; i++) begin
        t_d[i]       <= t_d[i-1];
        lo_d[i]      <= lo_d[i-1];
        hi_d[i]      <= hi_d[i-1];
        u_d[i]       <= u_d[i-1];
        byp_d[i]     <= byp_d[i-1];
        byp_val_d[i] <= byp_val_d[i-1];
      end
    end
  end

  assign below   = x < SW'(t_d[D-1]);
  assign lo_next = below ? u_d[D-1] : lo_d[D-1];
  assign hi_next = below ? hi_d[D-1] : u_d[D-1];
  assign mid     = {1'b0, lo_next} + {1'b0, hi_next};

  always_ff @(posedge clk) begin
    if (en) begin
      out_t       <= t_d[D-1];
      out_lo      <= lo_next;
      out_hi      <= hi_next;
      out_u       <= mid[VW:1];
      out_byp     <= byp_d[D-1];
      out_byp_val <= byp_val_d[D-1];
    end
  end

endmodule
